FILE: design/rdcwu_pkg.sv
package rdcwu_pkg;

  // Default sizes of the value array and of the code space
  localparam int unsigned ArrayDepthDef = 1024;
  localparam int unsigned CodeCountDef  = 1024;

  // Fixed widths of the word fields
  localparam int unsigned ActionW = 1;
  localparam int unsigned PosW    = 10;
  localparam int unsigned CodeW   = 10;
  localparam int unsigned CountW  = 11;

  // Request kinds
  localparam logic [ActionW-1:0] ActUpdate = 1'b0;
  localparam logic [ActionW-1:0] ActQuery  = 1'b1;

endpackage

FILE: design/rdcwu_if.sv
// Request channel: update or range query
interface rdcwu_req_if;
  logic                             valid;
  logic                             ready;
  logic [rdcwu_pkg::ActionW-1:0]    action;
  logic [rdcwu_pkg::PosW-1:0]       position;
  logic [rdcwu_pkg::CodeW-1:0]      value_code;
  logic [rdcwu_pkg::PosW-1:0]       range_first;
  logic [rdcwu_pkg::PosW-1:0]       range_last;

  modport source (
    output valid, action, position, value_code, range_first, range_last,
    input  ready
  );
  modport sink (
    input  valid, action, position, value_code, range_first, range_last,
    output ready
  );
endinterface

// Response channel: distinct count
interface rdcwu_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [rdcwu_pkg::CountW-1:0]     distinct_count;
  logic                             bad_range;

  modport source (
    output valid, distinct_count, bad_range,
    input  ready
  );
  modport sink (
    input  valid, distinct_count, bad_range,
    output ready
  );
endinterface

FILE: design/range_distinct_count_with_updates.sv
// Distinct-code counter over a sliding window with point updates. The block holds an array
// of ARRAY_DEPTH value codes and a per-code occurrence count over the current window, both
// in single-port-read memories. An update word writes a code at a position; when the
// position lies in the window the old code is counted out and the new one counted in. A
// query word walks the window edges one position per step to the requested inclusive range
// and answers the number of distinct codes in it; a query whose first position exceeds its
// last answers zero with bad_range set and leaves the window alone. Every word gets exactly
// one response word; an update past the array writes nothing. Each move of a window edge
// runs through the plan, value-memory read, count-memory read and count write-back steps,
// the write-back going through the shared +/-1 unit. The block takes no new word while it
// works on one, and it holds a finished response back while the output register still
// holds an unread one. After reset the block runs a clearing pass over the addresses up to
// max(ARRAY_DEPTH, CODE_COUNT) (1024 by default) before it takes its first word. A
// finished response waits in an output register while the next request is taken.
module range_distinct_count_with_updates #(
  parameter int unsigned ARRAY_DEPTH = rdcwu_pkg::ArrayDepthDef,
  parameter int unsigned CODE_COUNT  = rdcwu_pkg::CodeCountDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  rdcwu_req_if.sink          req_i,
  rdcwu_rsp_if.source        rsp_o
);

  localparam int unsigned PW    = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
  localparam int unsigned CW    = (CODE_COUNT > 1) ? $clog2(CODE_COUNT) : 1;
  localparam int unsigned CNTW  = $clog2(ARRAY_DEPTH + 1);
  localparam int unsigned MAXD  = (ARRAY_DEPTH > CODE_COUNT) ? ARRAY_DEPTH : CODE_COUNT;
  localparam int unsigned CLRW  = $clog2(MAXD);
  localparam int unsigned OUTW  = rdcwu_pkg::CountW;

  localparam logic signed [PW:0] OneS = (PW+1)'(1);

  // Sequencer states
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_PLAN  = 3'd2;
  localparam logic [2:0] ST_VRD   = 3'd3;
  localparam logic [2:0] ST_CRD   = 3'd4;
  localparam logic [2:0] ST_CWR   = 3'd5;
  localparam logic [2:0] ST_VWR   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  // Memories
  logic [CW-1:0]   vs_mem  [ARRAY_DEPTH];
  logic [CNTW-1:0] occ_mem [CODE_COUNT];
  logic [CW-1:0]   vs_rdata_q;
  logic [CNTW-1:0] occ_rdata_q;

  // Control state
  logic [2:0]      state_q, state_d;
  logic [CLRW-1:0] clr_q, clr_d;
  logic [PW-1:0]   win_first_q, win_first_d;
  logic [PW-1:0]   win_last_q, win_last_d;
  logic            win_empty_q, win_empty_d;
  logic [CNTW-1:0] total_q, total_d;
  logic            rsp_valid_q, rsp_valid_d;

  // Per-word working registers
  logic signed [PW:0] lo_q, lo_d, hi_q, hi_d, tf_q, tf_d, tl_q, tl_d;
  logic               is_query_q, is_query_d;
  logic               bad_q, bad_d;
  logic               inside_q, inside_d;
  logic               wrote_q, wrote_d;
  logic               step_out_q, step_out_d;
  logic [PW-1:0]      step_pos_q, step_pos_d;
  logic [PW-1:0]      upd_pos_q, upd_pos_d;
  logic [CW-1:0]      upd_code_q, upd_code_d;
  logic [OUTW-1:0]    rsp_count_q, rsp_count_d;
  logic               rsp_bad_q, rsp_bad_d;

  // Memory write ports
  logic            vs_we;
  logic [PW-1:0]   vs_waddr;
  logic [CW-1:0]   vs_wdata;
  logic            occ_we;
  logic [CW-1:0]   occ_waddr;
  logic [CNTW-1:0] occ_wdata;

  // Request decode
  logic [31:0]        pos32, code32, f32, l32;
  logic               pos_ok;
  logic [PW-1:0]      pos_n, f_n, l_n;
  logic [CW-1:0]      code_n;
  logic               inside_n;
  logic signed [PW:0] lo_m1, lo_p1, hi_m1, hi_p1;
  logic [CNTW-1:0]    occ_next;
  logic [CNTW+OUTW-1:0] total_ext;

  assign pos32    = 32'(req_i.position);
  assign code32   = 32'(req_i.value_code);
  assign f32      = 32'(req_i.range_first);
  assign l32      = 32'(req_i.range_last);
  assign pos_ok   = pos32 < ARRAY_DEPTH;
  assign pos_n    = PW'(pos32);
  assign code_n   = CW'((code32 >= CODE_COUNT) ? (CODE_COUNT - 1) : code32);
  assign f_n      = PW'((f32 >= ARRAY_DEPTH) ? (ARRAY_DEPTH - 1) : f32);
  assign l_n      = PW'((l32 >= ARRAY_DEPTH) ? (ARRAY_DEPTH - 1) : l32);
  assign inside_n = !win_empty_q && (pos_n >= win_first_q) && (pos_n <= win_last_q);

  // Edge neighbors
  assign lo_m1 = lo_q - OneS;
  assign lo_p1 = lo_q + OneS;
  assign hi_m1 = hi_q - OneS;
  assign hi_p1 = hi_q + OneS;

  // Shared +/-1 unit on the occurrence count
  assign occ_next  = step_out_q ? (occ_rdata_q - CNTW'(1)) : (occ_rdata_q + CNTW'(1));
  assign total_ext = (CNTW+OUTW)'(total_q);

  assign req_i.ready          = (state_q == ST_IDLE);
  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.distinct_count = rsp_count_q;
  assign rsp_o.bad_range      = rsp_bad_q;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    win_first_d = win_first_q;
    win_last_d  = win_last_q;
    win_empty_d = win_empty_q;
    total_d     = total_q;
    rsp_valid_d = rsp_valid_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    tf_d        = tf_q;
    tl_d        = tl_q;
    is_query_d  = is_query_q;
    bad_d       = bad_q;
    inside_d    = inside_q;
    wrote_d     = wrote_q;
    step_out_d  = step_out_q;
    step_pos_d  = step_pos_q;
    upd_pos_d   = upd_pos_q;
    upd_code_d  = upd_code_q;
    rsp_count_d = rsp_count_q;
    rsp_bad_d   = rsp_bad_q;
    vs_we       = 1'b0;
    vs_waddr    = upd_pos_q;
    vs_wdata    = upd_code_q;
    occ_we      = 1'b0;
    occ_waddr   = vs_rdata_q;
    occ_wdata   = occ_next;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        vs_we     = 32'(clr_q) < ARRAY_DEPTH;
        vs_waddr  = clr_q[PW-1:0];
        vs_wdata  = '0;
        occ_we    = 32'(clr_q) < CODE_COUNT;
        occ_waddr = clr_q[CW-1:0];
        occ_wdata = '0;
        clr_d     = clr_q + CLRW'(1);
        if (32'(clr_q) == MAXD - 1) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (req_i.valid) begin
          is_query_d = (req_i.action == rdcwu_pkg::ActQuery);
          bad_d      = 1'b0;
          wrote_d    = 1'b0;
          if (req_i.action == rdcwu_pkg::ActQuery) begin
            if (f_n > l_n) begin
              bad_d   = 1'b1;
              state_d = ST_DONE;
            end else begin
              tf_d    = $signed({1'b0, f_n});
              tl_d    = $signed({1'b0, l_n});
              lo_d    = $signed({1'b0, win_first_q});
              hi_d    = win_empty_q ? ($signed({1'b0, win_first_q}) - OneS)
                                    : $signed({1'b0, win_last_q});
              state_d = ST_PLAN;
            end
          end else begin
            upd_pos_d  = pos_n;
            upd_code_d = code_n;
            inside_d   = inside_n;
            step_pos_d = pos_n;
            step_out_d = 1'b1;
            if (!pos_ok) begin
              state_d = ST_DONE;
            end else if (inside_n) begin
              state_d = ST_VRD;
            end else begin
              state_d = ST_VWR;
            end
          end
        end
      end

      // Pick the next edge move, in the order grow left, grow right, shrink left, shrink right
      ST_PLAN: begin
        state_d = ST_VRD;
        if (lo_q > tf_q) begin
          lo_d       = lo_m1;
          step_pos_d = lo_m1[PW-1:0];
          step_out_d = 1'b0;
        end else if (hi_q < tl_q) begin
          hi_d       = hi_p1;
          step_pos_d = hi_p1[PW-1:0];
          step_out_d = 1'b0;
        end else if (lo_q < tf_q) begin
          lo_d       = lo_p1;
          step_pos_d = lo_q[PW-1:0];
          step_out_d = 1'b1;
        end else if (hi_q > tl_q) begin
          hi_d       = hi_m1;
          step_pos_d = hi_q[PW-1:0];
          step_out_d = 1'b1;
        end else begin
          win_first_d = lo_q[PW-1:0];
          win_last_d  = hi_q[PW-1:0];
          win_empty_d = 1'b0;
          state_d     = ST_DONE;
        end
      end

      // Value memory read in flight
      ST_VRD: begin
        state_d = ST_CRD;
      end

      // Count memory read in flight
      ST_CRD: begin
        state_d = ST_CWR;
      end

      // Count write-back and distinct total update
      ST_CWR: begin
        if (step_out_q) begin
          occ_we = (occ_rdata_q != '0);
          if (occ_rdata_q == CNTW'(1)) begin
            total_d = total_q - CNTW'(1);
          end
        end else begin
          occ_we = 1'b1;
          if (occ_rdata_q == '0) begin
            total_d = total_q + CNTW'(1);
          end
        end
        if (is_query_q) begin
          state_d = ST_PLAN;
        end else if (!wrote_q) begin
          state_d = ST_VWR;
        end else begin
          state_d = ST_DONE;
        end
      end

      // Store the new code, then count it in when inside the window
      ST_VWR: begin
        vs_we      = 1'b1;
        wrote_d    = 1'b1;
        step_pos_d = upd_pos_q;
        step_out_d = 1'b0;
        state_d    = inside_q ? ST_VRD : ST_DONE;
      end

      // Load the response register once it is free
      ST_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          rsp_bad_d   = bad_q;
          rsp_count_d = bad_q ? '0 : total_ext[OUTW-1:0];
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      win_first_q <= '0;
      win_last_q  <= '0;
      win_empty_q <= 1'b1;
      total_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      win_first_q <= win_first_d;
      win_last_q  <= win_last_d;
      win_empty_q <= win_empty_d;
      total_q     <= total_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    tf_q        <= tf_d;
    tl_q        <= tl_d;
    is_query_q  <= is_query_d;
    bad_q       <= bad_d;
    inside_q    <= inside_d;
    wrote_q     <= wrote_d;
    step_out_q  <= step_out_d;
    step_pos_q  <= step_pos_d;
    upd_pos_q   <= upd_pos_d;
    upd_code_q  <= upd_code_d;
    rsp_count_q <= rsp_count_d;
    rsp_bad_q   <= rsp_bad_d;
  end

  // Value memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (vs_we) begin
      vs_mem[vs_waddr] <= vs_wdata;
    end
    vs_rdata_q <= vs_mem[step_pos_q];
  end

  // Occurrence memory, addressed by the code just read
  always_ff @(posedge clk_i) begin
    if (occ_we) begin
      occ_mem[occ_waddr] <= occ_wdata;
    end
    occ_rdata_q <= occ_mem[vs_rdata_q];
  end

  // A flagged range always answers zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.bad_range |-> rsp_o.distinct_count == '0)
    else $error("bad range word with nonzero count");

  // A zero count is never decremented
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CWR) && step_out_q && (occ_rdata_q == '0) |-> !occ_we)
    else $error("occurrence count underflow");

  // The distinct total only moves on a count write-back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_CWR) |=> $stable(total_q))
    else $error("distinct total changed outside write-back");

  // A finished query leaves an ordered, non-empty window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PLAN) && (state_d == ST_DONE) |=>
      !win_empty_q && (win_first_q <= win_last_q))
    else $error("window left disordered after query");

  // No word is taken during the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |=> (total_q == '0) && win_empty_q)
    else $error("state disturbed during clearing pass");

endmodule
